### hdl/audio_peak_rms_meter_macros.svh
// Assertion macros for the meter's checker file.
`ifndef AUDIO_PEAK_RMS_METER_MACROS_SVH
`define AUDIO_PEAK_RMS_METER_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define APR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that is also checked while reset is high.
`define APR_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hdl/apr_pkg.sv
// Shared types and constants of the audio peak and RMS meter.
`timescale 1ns / 1ps

package apr_pkg;

  // Configuration port.
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_FORMAT    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PORT_OPEN = 1'd1;

  // Format code: bit 2 selects float samples, bits 1..0 select channels.
  localparam int FMT_FLOAT_BIT = 2;
  localparam logic [1:0] CH_MONO   = 2'd0;
  localparam logic [1:0] CH_STEREO = 2'd1;

  // Datapath widths.
  localparam int SAMPLE_W = 32;
  localparam int MAG_W    = 16;
  localparam int SQ_W     = 2 * MAG_W;
  localparam int ROOT_W   = 16;
  localparam int RAD_W    = 2 * ROOT_W;
  localparam int TOTAL_W  = 32;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_CLOSED   = 2'd1,
    STATUS_OVERFLOW = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CONV,
    ST_MUL,
    ST_ACC,
    ST_DIV_GO,
    ST_DIV,
    ST_SQRT_GO,
    ST_SQRT,
    ST_EMIT
  } state_t;

endpackage

### hdl/apr_conv.sv
// Sample converter: int16 or IEEE single to a saturated Q1.15 magnitude.
`timescale 1ns / 1ps

module apr_conv (
  input  logic                         clk,
  input  logic                         load,
  input  logic [apr_pkg::SAMPLE_W-1:0] sample_bits,
  input  logic                         float_fmt,
  output logic [apr_pkg::MAG_W-1:0]    mag
);

  logic        neg;
  logic [7:0]  ex;
  logic [22:0] man;
  logic [7:0]  shift_full;
  logic [4:0]  shift;
  logic [24:0] rounded;
  logic [24:0] scaled;
  logic [24:0] raw;
  logic [24:0] sat;
  logic [15:0] low;
  logic [15:0] int_mag;

  // Float path: scale by 2^15, round half away from zero, then saturate.
  always_comb begin
    neg        = sample_bits[31];
    ex         = sample_bits[30:23];
    man        = sample_bits[22:0];
    shift_full = 8'd135 - ex;
    shift      = shift_full[4:0];
    rounded    = {2'b01, man} + (25'd1 << (shift - 5'd1));
    scaled     = rounded >> shift;
    if (ex == 8'hFF) begin
      raw = (man != 23'd0) ? 25'd0 : 25'h10000;
    end else if (ex == 8'd0) begin
      raw = 25'd0;
    end else if (ex >= 8'd135) begin
      raw = 25'h10000;
    end else if (shift_full > 8'd25) begin
      raw = 25'd0;
    end else begin
      raw = scaled;
    end
    if (neg) begin
      sat = (raw > 25'd32768) ? 25'd32768 : raw;
    end else begin
      sat = (raw > 25'd32767) ? 25'd32767 : raw;
    end
  end

  // Integer path: magnitude of the low 16 bits as two's complement.
  always_comb begin
    low     = sample_bits[15:0];
    int_mag = low[15] ? (~low + 16'd1) : low;
  end

  // Register the magnitude for the squaring stage.
  always_ff @(posedge clk) begin
    if (load) begin
      mag <= float_fmt ? sat[apr_pkg::MAG_W-1:0] : int_mag;
    end
  end

endmodule

### hdl/apr_div.sv
// Bit-serial restoring divider: one quotient bit per cycle.
`timescale 1ns / 1ps

module apr_div #(
  parameter int DIVIDEND_W = 43,
  parameter int DIVISOR_W  = 13
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]  divisor,
  output logic                  done,
  output logic [DIVIDEND_W-1:0] quotient
);

  localparam int STEP_W = $clog2(DIVIDEND_W);

  logic [DIVISOR_W-1:0] rem;
  logic [DIVISOR_W-1:0] dvs;
  logic [STEP_W-1:0]    step;
  logic                 busy;
  logic [DIVISOR_W:0]   trial;
  logic [DIVISOR_W:0]   diff;
  logic                 fits;

  // One trial subtraction of the divisor from the partial remainder.
  always_comb begin
    trial = {rem, quotient[DIVIDEND_W-1]};
    diff  = trial - {1'b0, dvs};
    fits  = (trial >= {1'b0, dvs});
  end

  // Step counter and completion pulse.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= STEP_W'(DIVIDEND_W - 1);
      end else if (busy) begin
        if (step == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          step <= step - 1'b1;
        end
      end
    end
  end

  // Dividend bits shift out at the top while quotient bits shift in below.
  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
      dvs      <= divisor;
    end else if (busy) begin
      quotient <= {quotient[DIVIDEND_W-2:0], fits};
      rem      <= fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
    end
  end

endmodule

### hdl/apr_sqrt.sv
// Digit-serial integer square root: one root bit per cycle.
`timescale 1ns / 1ps

module apr_sqrt (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [apr_pkg::RAD_W-1:0]  radicand,
  output logic                       done,
  output logic [apr_pkg::ROOT_W-1:0] root
);

  localparam int REM_W  = apr_pkg::ROOT_W + 2;
  localparam int STEP_W = $clog2(apr_pkg::ROOT_W);

  logic [apr_pkg::RAD_W-1:0] rad;
  logic [REM_W-1:0]          rem;
  logic [STEP_W-1:0]         step;
  logic                      busy;
  logic [REM_W+1:0]          shifted;
  logic [REM_W+1:0]          trial;
  logic [REM_W+1:0]          diff;
  logic                      fits;

  // Bring down two radicand bits and try the next root bit.
  always_comb begin
    shifted = {rem, rad[apr_pkg::RAD_W-1 -: 2]};
    trial   = {2'b00, root, 2'b01};
    diff    = shifted - trial;
    fits    = (shifted >= trial);
  end

  // Step counter and completion pulse.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= STEP_W'(apr_pkg::ROOT_W - 1);
      end else if (busy) begin
        if (step == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          step <= step - 1'b1;
        end
      end
    end
  end

  // Radicand, remainder and root shift registers.
  always_ff @(posedge clk) begin
    if (start) begin
      rad  <= radicand;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      rad  <= {rad[apr_pkg::RAD_W-3:0], 2'b00};
      rem  <= fits ? diff[REM_W-1:0] : shifted[REM_W-1:0];
      root <= {root[apr_pkg::ROOT_W-2:0], fits};
    end
  end

endmodule

### hdl/audio_peak_rms_meter.sv
// Top level of the audio peak and RMS meter.
//
//   channel  dir  tdata bits (low first)                          tuser / tlast
//   s_       in   [31:0] sample_bits                              tlast: last
//   m_       out  peak, rms, call, frame, sample, byte totals     tuser[1:0]: status
//   cfg_     in   cfg_wdata[2:0] into register cfg_index          write on cfg_wen
//
// A sample that is not last of its buffer passes accept, convert, square and
// accumulate. A last sample also runs the bit-serial divider (SUM_W steps) and the
// square root unit (16 steps) before its result is emitted; a last sample with the
// port closed goes from accept straight to emit, and one that overflowed skips both.
// Reset is synchronous and clears the configuration, statistics and output valid.
// A result waits in the output register; the next samples are taken meanwhile,
// and only a further result stalls until that beat has been taken.
`timescale 1ns / 1ps

module audio_peak_rms_meter #(
  parameter int MAX_BUFFER_SAMPLES = 4096
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [31:0]                    s_tdata,   // [31:0] sample_bits
  input  logic                           s_tlast,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // [15:0] peak_level, [31:16] rms_level, [63:32] call_total,
  // [95:64] frame_total, [127:96] sample_total, [159:128] byte_total
  output logic [159:0]                   m_tdata,
  output logic [1:0]                     m_tuser,   // [1:0] status
  output logic                           m_tvalid,
  input  logic                           m_tready,
  input  logic                           cfg_wen,
  input  logic [apr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [apr_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam int CNT_W = $clog2(MAX_BUFFER_SAMPLES + 2);
  localparam int SUM_W = $clog2(MAX_BUFFER_SAMPLES) + 31;
  localparam int TW    = apr_pkg::TOTAL_W;

  apr_pkg::state_t  state;
  apr_pkg::state_t  state_next;
  apr_pkg::status_t status_reg;

  logic [2:0]                   format_code;
  logic                         port_open;
  logic [apr_pkg::SAMPLE_W-1:0] sample_reg;
  logic                         last_reg;
  logic [2:0]                   fmt_reg;
  logic [apr_pkg::MAG_W-1:0]    mag;
  logic [apr_pkg::SQ_W-1:0]     sq_reg;
  logic [apr_pkg::MAG_W-1:0]    peak_reg;
  logic [SUM_W-1:0]             square_sum;
  logic [CNT_W-1:0]             buffer_count;
  logic [TW-1:0]                calls_reg;
  logic [TW-1:0]                frames_reg;
  logic [TW-1:0]                samples_reg;
  logic [TW-1:0]                bytes_reg;

  logic                         cnt_full;
  logic                         out_free;
  logic                         conv_load;
  logic                         div_start;
  logic                         div_done;
  logic [SUM_W-1:0]             quotient;
  logic                         sqrt_start;
  logic                         sqrt_done;
  logic [apr_pkg::ROOT_W-1:0]   root;
  logic                         emit_load;
  logic                         status_ok;

  logic [TW-1:0] n_ext;
  logic [TW-1:0] frame_delta;
  logic [TW-1:0] byte_delta;
  logic [TW-1:0] calls_next;
  logic [TW-1:0] frames_next;
  logic [TW-1:0] samples_next;
  logic [TW-1:0] bytes_next;
  logic [apr_pkg::ROOT_W-1:0] rms_out;

  assign cnt_full  = (buffer_count >= CNT_W'(MAX_BUFFER_SAMPLES));
  assign out_free  = !m_tvalid || m_tready;
  assign status_ok = (status_reg == apr_pkg::STATUS_OK);

  // Sample converter, serial divider and serial square root.
  apr_conv u_conv (
    .clk         (clk),
    .load        (conv_load),
    .sample_bits (sample_reg),
    .float_fmt   (fmt_reg[apr_pkg::FMT_FLOAT_BIT]),
    .mag         (mag)
  );

  apr_div #(
    .DIVIDEND_W (SUM_W),
    .DIVISOR_W  (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (square_sum),
    .divisor  (buffer_count),
    .done     (div_done),
    .quotient (quotient)
  );

  apr_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sqrt_start),
    .radicand (quotient[apr_pkg::RAD_W-1:0]),
    .done     (sqrt_done),
    .root     (root)
  );

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      apr_pkg::ST_IDLE: begin
        if (s_tvalid) begin
          if (!port_open) begin
            state_next = s_tlast ? apr_pkg::ST_EMIT : apr_pkg::ST_IDLE;
          end else begin
            state_next = apr_pkg::ST_CONV;
          end
        end
      end
      apr_pkg::ST_CONV: state_next = apr_pkg::ST_MUL;
      apr_pkg::ST_MUL:  state_next = apr_pkg::ST_ACC;
      apr_pkg::ST_ACC: begin
        if (!last_reg) begin
          state_next = apr_pkg::ST_IDLE;
        end else if (cnt_full) begin
          state_next = apr_pkg::ST_EMIT;
        end else begin
          state_next = apr_pkg::ST_DIV_GO;
        end
      end
      apr_pkg::ST_DIV_GO: state_next = apr_pkg::ST_DIV;
      apr_pkg::ST_DIV: begin
        if (div_done) begin
          state_next = apr_pkg::ST_SQRT_GO;
        end
      end
      apr_pkg::ST_SQRT_GO: state_next = apr_pkg::ST_SQRT;
      apr_pkg::ST_SQRT: begin
        if (sqrt_done) begin
          state_next = apr_pkg::ST_EMIT;
        end
      end
      apr_pkg::ST_EMIT: begin
        if (out_free) begin
          state_next = apr_pkg::ST_IDLE;
        end
      end
      default: state_next = apr_pkg::ST_IDLE;
    endcase
  end

  // State decoded controls.
  always_comb begin
    s_tready   = (state == apr_pkg::ST_IDLE);
    conv_load  = (state == apr_pkg::ST_CONV);
    div_start  = (state == apr_pkg::ST_DIV_GO);
    sqrt_start = (state == apr_pkg::ST_SQRT_GO);
    emit_load  = (state == apr_pkg::ST_EMIT) && out_free;
  end

  // Totals after this buffer, with the format seen on its last sample.
  always_comb begin
    n_ext = {{(TW-CNT_W){1'b0}}, buffer_count};
    case (fmt_reg[1:0])
      apr_pkg::CH_MONO:   frame_delta = n_ext;
      apr_pkg::CH_STEREO: frame_delta = n_ext >> 1;
      default:            frame_delta = n_ext >> 3;
    endcase
    byte_delta   = fmt_reg[apr_pkg::FMT_FLOAT_BIT] ? (n_ext << 2) : (n_ext << 1);
    calls_next   = calls_reg + 1'b1;
    frames_next  = frames_reg + frame_delta;
    samples_next = samples_reg + n_ext;
    bytes_next   = bytes_reg + byte_delta;
    rms_out      = status_ok ? root : '0;
  end

  // Control and statistics registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= apr_pkg::ST_IDLE;
      format_code  <= '0;
      port_open    <= 1'b0;
      peak_reg     <= '0;
      square_sum   <= '0;
      buffer_count <= '0;
      calls_reg    <= '0;
      frames_reg   <= '0;
      samples_reg  <= '0;
      bytes_reg    <= '0;
      m_tvalid     <= 1'b0;
    end else begin
      state <= state_next;

      // Configuration writes; opening or closing the port clears the statistics.
      if (cfg_wen) begin
        case (cfg_index)
          apr_pkg::REG_FORMAT: format_code <= cfg_wdata;
          apr_pkg::REG_PORT_OPEN: begin
            port_open    <= cfg_wdata[0];
            peak_reg     <= '0;
            square_sum   <= '0;
            buffer_count <= '0;
            calls_reg    <= '0;
            frames_reg   <= '0;
            samples_reg  <= '0;
            bytes_reg    <= '0;
          end
          default: ;
        endcase
      end

      // Accumulate one sample, or mark the buffer overflowed.
      if (state == apr_pkg::ST_ACC) begin
        if (cnt_full) begin
          buffer_count <= CNT_W'(MAX_BUFFER_SAMPLES + 1);
          if (last_reg) begin
            square_sum   <= '0;
            buffer_count <= '0;
          end
        end else begin
          if (mag > peak_reg) begin
            peak_reg <= mag;
          end
          square_sum   <= square_sum + {{(SUM_W-apr_pkg::SQ_W){1'b0}}, sq_reg};
          buffer_count <= buffer_count + 1'b1;
        end
      end

      // Output beat handshake and end of buffer update.
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (emit_load) begin
        m_tvalid <= 1'b1;
        if (status_ok) begin
          calls_reg    <= calls_next;
          frames_reg   <= frames_next;
          samples_reg  <= samples_next;
          bytes_reg    <= bytes_next;
          square_sum   <= '0;
          buffer_count <= '0;
        end
      end
    end
  end

  // Sample capture, square and output payload.
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      sample_reg <= s_tdata;
      last_reg   <= s_tlast;
      fmt_reg    <= format_code;
      if (!port_open) begin
        status_reg <= apr_pkg::STATUS_CLOSED;
      end
    end
    if (state == apr_pkg::ST_MUL) begin
      sq_reg <= mag * mag;
    end
    if ((state == apr_pkg::ST_ACC) && last_reg) begin
      status_reg <= cnt_full ? apr_pkg::STATUS_OVERFLOW : apr_pkg::STATUS_OK;
    end
    if (emit_load) begin
      m_tuser <= status_reg;
      if (status_ok) begin
        m_tdata <= {bytes_next, samples_next, frames_next, calls_next, rms_out, peak_reg};
      end else begin
        m_tdata <= {bytes_reg, samples_reg, frames_reg, calls_reg, rms_out, peak_reg};
      end
    end
  end

endmodule

### hdl/apr_checker.sv
// Port-level checks of the audio peak and RMS meter, bound to the top level.
`timescale 1ns / 1ps
`include "audio_peak_rms_meter_macros.svh"

module apr_checker (
  input logic         clk,
  input logic         rst,
  input logic [159:0] m_tdata,
  input logic [1:0]   m_tuser,
  input logic         m_tvalid,
  input logic         m_tready
);

  // A stalled result beat holds its payload.
  `APR_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result beat changed while stalled")

  // Reset leaves no result pending.
  `APR_ASSERT_ALWAYS(a_reset_empty, rst |=> !m_tvalid, "result valid after reset")

  // A rejected or overflowed buffer reports a zero RMS level.
  `APR_ASSERT(a_rms_zero, m_tvalid && (m_tuser != apr_pkg::STATUS_OK) |-> (m_tdata[31:16] == 16'd0), "nonzero rms on error status")

  // The RMS of a buffer never exceeds the running peak.
  `APR_ASSERT(a_rms_le_peak, m_tvalid && (m_tuser == apr_pkg::STATUS_OK) |-> (m_tdata[31:16] <= m_tdata[15:0]), "rms above peak")

endmodule

bind audio_peak_rms_meter apr_checker u_apr_checker (.*);
